/* sv/event_voxel_grid_accumulator_defines.svh */
`ifndef EVENT_VOXEL_GRID_ACCUMULATOR_DEFINES_SVH
`define EVENT_VOXEL_GRID_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, checked at every edge out of reset.
`define EVGA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every edge out of reset.
`define EVGA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/evga_pkg.sv */
package evga_pkg;

  typedef logic [47:0]        time_t;
  typedef logic signed [31:0] cell_t;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_EVENT  = 2'd1,
    OP_FINISH = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BEGIN_DIV,
    ST_BEGIN_WAIT,
    ST_EV_CHECK,
    ST_EV_MUL_LO,
    ST_EV_MUL_HI,
    ST_EV_RD_L,
    ST_EV_WR_L,
    ST_EV_RD_R,
    ST_EV_WR_R,
    ST_FIN_WALK,
    ST_FIN_MEAN,
    ST_FIN_MEAN_WAIT,
    ST_FIN_MSQ,
    ST_FIN_VAR_WAIT,
    ST_FIN_SQRT_WAIT,
    ST_FIN_INV_WAIT,
    ST_RD_MEM,
    ST_RD_CALC,
    ST_RD_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
  localparam logic [24:0] INV_CLAMP = 25'h1FF_FFFF;

endpackage

/* sv/evga_div.sv */
module evga_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [63:0]           dividend,
  input  logic [63:0]           divisor,
  output logic [63:0]           quotient,
  output evga_pkg::unit_status_t status
);
  import evga_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] dvs_r, dvs_nxt;
  logic [64:0] trial;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[63]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 64'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient    = quo_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

/* sv/evga_sqrt.sv */
module evga_sqrt (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [63:0]           radicand,
  output logic [31:0]           root,
  output evga_pkg::unit_status_t status
);
  import evga_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [63:0] v_r, v_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [63:0] trial;

  // Digit-by-digit integer square root, two radicand bits per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    trial    = res_r + bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      v_nxt    = radicand;
      res_nxt  = '0;
      bit_nxt  = 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_nxt   = v_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign root        = res_r[31:0];
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

/* sv/event_voxel_grid_accumulator.sv */
// Requests: one at a time, as in_ready is high only in idle. An event is dropped, or binned
// by up to two read-modify-write passes through the cell memory; a read also waits for out.
// Reset: a clearing pass over all N = TIME_BINS*GRID_HEIGHT*GRID_WIDTH cells zeroes the
// grid, in_ready stays low meanwhile; configuration writes are taken at any time.
`include "event_voxel_grid_accumulator_defines.svh"

module event_voxel_grid_accumulator #(
  parameter int TIME_BINS   = 5,
  parameter int GRID_HEIGHT = 64,
  parameter int GRID_WIDTH  = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [10:0]     cfg_crop_x_offset,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_op,
  input  evga_pkg::time_t in_window_start,
  input  evga_pkg::time_t in_window_end,
  input  evga_pkg::time_t in_event_time,
  input  logic [10:0]     in_event_x,
  input  logic [9:0]      in_event_y,
  input  logic            in_event_polarity,
  input  logic [14:0]     in_cell_index,
  output logic            out_valid,
  input  logic            out_ready,
  output evga_pkg::cell_t out_cell_value,
  output logic            out_was_normalized
);
  import evga_pkg::*;

  localparam int PLANE      = GRID_HEIGHT * GRID_WIDTH;
  localparam int CELL_COUNT = TIME_BINS * PLANE;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int SUM_W      = 32 + CNT_W;

  // Cell memory: one write port, one registered read port.
  cell_t          mem [0:CELL_COUNT-1];
  cell_t          mem_q_r;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  cell_t          mem_wdata;

  // Control and architectural state.
  state_t         state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic           begin_pend_r, begin_pend_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [10:0]    crop_r, crop_nxt;
  time_t          start_r, start_nxt;
  time_t          end_r, end_nxt;
  logic [31:0]    ts_r, ts_nxt;
  cell_t          cell_mean_r, cell_mean_nxt;
  logic [31:0]    inv_r, inv_nxt;
  logic           stats_valid_r, stats_valid_nxt;
  logic           p1_r, p1_nxt;
  logic           p2_r, p2_nxt;

  // Working registers.
  time_t          dur_r, dur_nxt;
  time_t          t_r, t_nxt;
  logic [10:0]    ex_r, ex_nxt;
  logic [9:0]     ey_r, ey_nxt;
  logic           pol_r, pol_nxt;
  time_t          delta_r, delta_nxt;
  logic [31:0]    tn_r, tn_nxt;
  logic [AW-1:0]  sp_r, sp_nxt;
  logic [14:0]    idx_r, idx_nxt;
  logic           rd_ok_r, rd_ok_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [63:0]    sumsq_r, sumsq_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  cell_t          v_r, v_nxt;
  logic [47:0]    sq_r, sq_nxt;
  logic signed [32:0] mean_r, mean_nxt;
  logic [47:0]    msq_r, msq_nxt;
  cell_t          val_r, val_nxt;
  logic           norm_r, norm_nxt;
  logic signed [58:0] prod_r, prod_nxt;
  cell_t          out_value_r, out_value_nxt;
  logic           out_norm_r, out_norm_nxt;

  // Arithmetic units: a shared divider and a square-root unit.
  logic           div_start, sqrt_start;
  logic [63:0]    div_a, div_b, div_q, sqrt_a;
  logic [31:0]    sqrt_root;
  unit_status_t   div_st, sqrt_st;

  // Combinational temporaries.
  logic [3:0]     bin;
  logic           left_ok, right_ok;
  logic [AW-1:0]  addr_l, addr_r;
  logic [16:0]    w_right, w_left, w_sel;
  logic [23:0]    mul_a;
  logic [55:0]    pp;
  logic signed [33:0] upd_cur, upd_acc;
  cell_t          upd_val;
  logic [10:0]    xg;
  logic signed [63:0] sq_full;
  logic [64:0]    sumsq_add;
  logic [SUM_W-1:0] sum_mag;
  logic [31:0]    mean_mag;
  logic [63:0]    msq_full;
  logic [63:0]    var64;
  cell_t          rd_val;
  logic signed [32:0] diff;
  logic [24:0]    invc;
  logic signed [58:0] prod_adj, prod_q;
  cell_t          norm_val;

  evga_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (div_q),
    .status   (div_st)
  );

  evga_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sqrt_a),
    .root     (sqrt_root),
    .status   (sqrt_st)
  );

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    begin_pend_nxt  = begin_pend_r;
    out_valid_nxt   = out_valid_r;
    crop_nxt        = crop_r;
    start_nxt       = start_r;
    end_nxt         = end_r;
    ts_nxt          = ts_r;
    cell_mean_nxt   = cell_mean_r;
    inv_nxt         = inv_r;
    stats_valid_nxt = stats_valid_r;
    p1_nxt          = p1_r;
    p2_nxt          = p2_r;
    dur_nxt         = dur_r;
    t_nxt           = t_r;
    ex_nxt          = ex_r;
    ey_nxt          = ey_r;
    pol_nxt         = pol_r;
    delta_nxt       = delta_r;
    tn_nxt          = tn_r;
    sp_nxt          = sp_r;
    idx_nxt         = idx_r;
    rd_ok_nxt       = rd_ok_r;
    sum_nxt         = sum_r;
    sumsq_nxt       = sumsq_r;
    n_nxt           = n_r;
    v_nxt           = v_r;
    sq_nxt          = sq_r;
    mean_nxt        = mean_r;
    msq_nxt         = msq_r;
    val_nxt         = val_r;
    norm_nxt        = norm_r;
    prod_nxt        = prod_r;
    out_value_nxt   = out_value_r;
    out_norm_nxt    = out_norm_r;

    in_ready   = (state_r == ST_IDLE);
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = cnt_r[AW-1:0];
    mem_raddr  = cnt_r[AW-1:0];
    mem_wdata  = '0;
    div_start  = 1'b0;
    div_a      = '0;
    div_b      = '0;
    sqrt_start = 1'b0;
    sqrt_a     = '0;

    // Event bin split: integer bin in the top nibble, right weight below it.
    bin      = tn_r[31:28];
    left_ok  = {28'd0, bin} < 32'(TIME_BINS);
    right_ok = ({28'd0, bin} + 32'd1) < 32'(TIME_BINS);
    addr_l   = AW'({28'd0, bin} * 32'(PLANE) + 32'(sp_r));
    addr_r   = AW'(({28'd0, bin} + 32'd1) * 32'(PLANE) + 32'(sp_r));
    w_right  = {1'b0, tn_r[27:12]};
    w_left   = 17'h1_0000 - w_right;
    w_sel    = (state_r == ST_EV_WR_L) ? w_left : w_right;

    // Saturating cell update from the word just read.
    upd_cur = 34'(mem_q_r);
    upd_acc = pol_r ? upd_cur + $signed({17'd0, w_sel}) : upd_cur - $signed({17'd0, w_sel});
    if (upd_acc > 34'sd2147483647) begin
      upd_val = 32'sh7FFF_FFFF;
    end else if (upd_acc < -34'sd2147483648) begin
      upd_val = 32'sh8000_0000;
    end else begin
      upd_val = upd_acc[31:0];
    end

    // One 24x32 multiplier serves both halves of the elapsed time.
    mul_a = (state_r == ST_EV_MUL_HI) ? delta_r[47:24] : delta_r[23:0];
    pp    = {32'd0, mul_a} * {24'd0, ts_r};
    xg    = ex_r - crop_r;

    sq_full   = mem_q_r * mem_q_r;
    sumsq_add = {1'b0, sumsq_r} + {17'd0, sq_r};
    sum_mag   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    mean_mag  = mean_r[32] ? 32'(-mean_r) : mean_r[31:0];
    msq_full  = {32'd0, mean_mag} * {32'd0, mean_mag};
    var64     = div_q - {16'd0, msq_r};

    // Read path: centered value times clamped inverse deviation.
    rd_val   = rd_ok_r ? mem_q_r : '0;
    diff     = 33'(rd_val) - 33'(cell_mean_r);
    invc     = (inv_r > {7'd0, INV_CLAMP}) ? INV_CLAMP : inv_r[24:0];
    prod_adj = prod_r + (prod_r[58] ? 59'sd65535 : 59'sd0);
    prod_q   = prod_adj >>> 16;
    if (prod_q > 59'sd2147483647) begin
      norm_val = 32'sh7FFF_FFFF;
    end else if (prod_q < -59'sd2147483648) begin
      norm_val = 32'sh8000_0000;
    end else begin
      norm_val = prod_q[31:0];
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_valid) begin
      crop_nxt = cfg_crop_x_offset;
    end

    case (state_r)
      ST_CLEAR: begin
        // Zero one cell per cycle.
        mem_we = 1'b1;
        if (cnt_r == CNT_W'(CELL_COUNT - 1)) begin
          cnt_nxt        = '0;
          begin_pend_nxt = 1'b0;
          state_nxt      = begin_pend_r ? ST_BEGIN_DIV : ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (op_t'(in_op))
            OP_BEGIN: begin
              start_nxt       = in_window_start;
              end_nxt         = in_window_end;
              dur_nxt         = (in_window_end > in_window_start) ?
                                in_window_end - in_window_start : 48'd1;
              stats_valid_nxt = 1'b0;
              cell_mean_nxt   = '0;
              inv_nxt         = ONE_Q16;
              begin_pend_nxt  = 1'b1;
              cnt_nxt         = '0;
              state_nxt       = ST_CLEAR;
            end
            OP_EVENT: begin
              t_nxt     = in_event_time;
              ex_nxt    = in_event_x;
              ey_nxt    = in_event_y;
              pol_nxt   = in_event_polarity;
              state_nxt = ST_EV_CHECK;
            end
            OP_FINISH: begin
              cnt_nxt   = '0;
              sum_nxt   = '0;
              sumsq_nxt = '0;
              n_nxt     = '0;
              p1_nxt    = 1'b0;
              p2_nxt    = 1'b0;
              state_nxt = ST_FIN_WALK;
            end
            OP_READ: begin
              idx_nxt   = in_cell_index;
              rd_ok_nxt = {17'd0, in_cell_index} < 32'(CELL_COUNT);
              state_nxt = ST_RD_MEM;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_BEGIN_DIV: begin
        div_start = 1'b1;
        div_a     = 64'(TIME_BINS - 1) << 28;
        div_b     = {16'd0, dur_r};
        state_nxt = ST_BEGIN_WAIT;
      end
      ST_BEGIN_WAIT: begin
        if (div_st.done) begin
          ts_nxt    = div_q[31:0];
          state_nxt = ST_IDLE;
        end
      end
      ST_EV_CHECK: begin
        // Drop events outside the window or the cropped grid.
        if ((t_r < start_r) || (t_r >= end_r) || (ex_r < crop_r) ||
            ({21'd0, xg} >= 32'(GRID_WIDTH)) || ({22'd0, ey_r} >= 32'(GRID_HEIGHT))) begin
          state_nxt = ST_IDLE;
        end else begin
          delta_nxt = t_r - start_r;
          sp_nxt    = AW'({22'd0, ey_r} * 32'(GRID_WIDTH) + {21'd0, xg});
          state_nxt = ST_EV_MUL_LO;
        end
      end
      ST_EV_MUL_LO: begin
        tn_nxt    = pp[31:0];
        state_nxt = ST_EV_MUL_HI;
      end
      ST_EV_MUL_HI: begin
        // The full product stays below 2^32 inside the window.
        tn_nxt    = tn_r + {pp[7:0], 24'd0};
        state_nxt = ST_EV_RD_L;
      end
      ST_EV_RD_L: begin
        if (left_ok) begin
          mem_re    = 1'b1;
          mem_raddr = addr_l;
          state_nxt = ST_EV_WR_L;
        end else begin
          state_nxt = ST_EV_RD_R;
        end
      end
      ST_EV_WR_L: begin
        mem_we    = 1'b1;
        mem_waddr = addr_l;
        mem_wdata = upd_val;
        state_nxt = ST_EV_RD_R;
      end
      ST_EV_RD_R: begin
        if (right_ok) begin
          mem_re    = 1'b1;
          mem_raddr = addr_r;
          state_nxt = ST_EV_WR_R;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EV_WR_R: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = upd_val;
        state_nxt = ST_IDLE;
      end
      ST_FIN_WALK: begin
        // Three-stage walk: read, square, accumulate.
        p1_nxt = 1'b0;
        if (cnt_r != CNT_W'(CELL_COUNT)) begin
          mem_re  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          p1_nxt  = 1'b1;
        end
        p2_nxt = p1_r;
        v_nxt  = mem_q_r;
        sq_nxt = sq_full[63:16];
        if (p2_r && (v_r != 0)) begin
          sum_nxt   = sum_r + SUM_W'(v_r);
          sumsq_nxt = sumsq_add[64] ? '1 : sumsq_add[63:0];
          n_nxt     = n_r + 1'b1;
        end
        if ((cnt_r == CNT_W'(CELL_COUNT)) && !p1_r && !p2_r) begin
          if (n_r == 0) begin
            stats_valid_nxt = 1'b0;
            cell_mean_nxt   = '0;
            inv_nxt         = ONE_Q16;
            state_nxt       = ST_IDLE;
          end else begin
            state_nxt = ST_FIN_MEAN;
          end
        end
      end
      ST_FIN_MEAN: begin
        div_start = 1'b1;
        div_a     = 64'(sum_mag);
        div_b     = 64'(n_r);
        state_nxt = ST_FIN_MEAN_WAIT;
      end
      ST_FIN_MEAN_WAIT: begin
        if (div_st.done) begin
          // Truncate toward zero: divide the magnitude, restore the sign.
          mean_nxt  = sum_r[SUM_W-1] ? -$signed({1'b0, div_q[31:0]}) :
                                       $signed({1'b0, div_q[31:0]});
          state_nxt = ST_FIN_MSQ;
        end
      end
      ST_FIN_MSQ: begin
        msq_nxt   = msq_full[63:16];
        div_start = 1'b1;
        div_a     = sumsq_r;
        div_b     = 64'(n_r);
        state_nxt = ST_FIN_VAR_WAIT;
      end
      ST_FIN_VAR_WAIT: begin
        if (div_st.done) begin
          cell_mean_nxt   = mean_r[31:0];
          stats_valid_nxt = 1'b1;
          if (!var64[63] && (var64 != 0)) begin
            sqrt_start = 1'b1;
            sqrt_a     = {var64[47:0], 16'd0};
            state_nxt  = ST_FIN_SQRT_WAIT;
          end else begin
            inv_nxt   = ONE_Q16;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FIN_SQRT_WAIT: begin
        if (sqrt_st.done) begin
          if (sqrt_root == 0) begin
            inv_nxt   = ONE_Q16;
            state_nxt = ST_IDLE;
          end else begin
            div_start = 1'b1;
            div_a     = 64'h0000_0001_0000_0000;
            div_b     = {32'd0, sqrt_root};
            state_nxt = ST_FIN_INV_WAIT;
          end
        end
      end
      ST_FIN_INV_WAIT: begin
        if (div_st.done) begin
          inv_nxt   = (div_q[63:32] != 0) ? 32'hFFFF_FFFF : div_q[31:0];
          state_nxt = ST_IDLE;
        end
      end
      ST_RD_MEM: begin
        if (rd_ok_r) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_r);
        end
        state_nxt = ST_RD_CALC;
      end
      ST_RD_CALC: begin
        val_nxt   = rd_val;
        norm_nxt  = (rd_val != 0) && stats_valid_r;
        prod_nxt  = diff * $signed({1'b0, invc});
        state_nxt = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = norm_r ? norm_val : val_r;
          out_norm_nxt  = norm_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      cnt_r         <= '0;
      begin_pend_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      crop_r        <= '0;
      start_r       <= '0;
      end_r         <= '0;
      ts_r          <= '0;
      cell_mean_r   <= '0;
      inv_r         <= ONE_Q16;
      stats_valid_r <= 1'b0;
      p1_r          <= 1'b0;
      p2_r          <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      begin_pend_r  <= begin_pend_nxt;
      out_valid_r   <= out_valid_nxt;
      crop_r        <= crop_nxt;
      start_r       <= start_nxt;
      end_r         <= end_nxt;
      ts_r          <= ts_nxt;
      cell_mean_r   <= cell_mean_nxt;
      inv_r         <= inv_nxt;
      stats_valid_r <= stats_valid_nxt;
      p1_r          <= p1_nxt;
      p2_r          <= p2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dur_r       <= dur_nxt;
    t_r         <= t_nxt;
    ex_r        <= ex_nxt;
    ey_r        <= ey_nxt;
    pol_r       <= pol_nxt;
    delta_r     <= delta_nxt;
    tn_r        <= tn_nxt;
    sp_r        <= sp_nxt;
    idx_r       <= idx_nxt;
    rd_ok_r     <= rd_ok_nxt;
    sum_r       <= sum_nxt;
    sumsq_r     <= sumsq_nxt;
    n_r         <= n_nxt;
    v_r         <= v_nxt;
    sq_r        <= sq_nxt;
    mean_r      <= mean_nxt;
    msq_r       <= msq_nxt;
    val_r       <= val_nxt;
    norm_r      <= norm_nxt;
    prod_r      <= prod_nxt;
    out_value_r <= out_value_nxt;
    out_norm_r  <= out_norm_nxt;
  end

  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_cell_value     = out_value_r;
  assign out_was_normalized = out_norm_r;

  // Cell writes come only from the clearing pass or an event update.
  `EVGA_ASSERT_NOW(a_write_source, mem_we,
    (state_r == ST_CLEAR) || (state_r == ST_EV_WR_L) || (state_r == ST_EV_WR_R),
    "cell write outside clear or update")
  // A left update write always follows the read of the same cell.
  `EVGA_ASSERT_NOW(a_rmw_pair, (state_r == ST_EV_WR_L), ($past(state_r) == ST_EV_RD_L),
    "left update without its read")
  // Every accepted request takes the block out of idle in the next cycle.
  `EVGA_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_r != ST_IDLE,
    "request accepted without work")
  // Divider results land only in a state waiting for them.
  `EVGA_ASSERT_NOW(a_div_owner, div_st.done,
    (state_r == ST_BEGIN_WAIT) || (state_r == ST_FIN_MEAN_WAIT) ||
    (state_r == ST_FIN_VAR_WAIT) || (state_r == ST_FIN_INV_WAIT),
    "divider result unclaimed")
  // Never start an arithmetic unit while either unit is still busy.
  `EVGA_ASSERT_NOW(a_unit_free, div_start || sqrt_start, !div_st.busy && !sqrt_st.busy,
    "unit restarted while busy")

endmodule

/* bench/tb_event_voxel_grid_accumulator.sv */
module tb_event_voxel_grid_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  import evga_pkg::*;

  localparam int BINS   = 5;
  localparam int HEIGHT = 64;
  localparam int WIDTH  = 64;
  localparam int PLANE  = HEIGHT * WIDTH;
  localparam int CELLS  = BINS * PLANE;
  localparam longint CYCLE_LIMIT = 5_000_000;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    cell_t value;
    logic  norm;
  } cell_read_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_crop_x_offset;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  time_t       in_window_start;
  time_t       in_window_end;
  time_t       in_event_time;
  logic [10:0] in_event_x;
  logic [9:0]  in_event_y;
  logic        in_event_polarity;
  logic [14:0] in_cell_index;
  logic        out_valid;
  logic        out_ready;
  cell_t       out_cell_value;
  logic        out_was_normalized;

  // Shadow copy of the grid and the frame statistics.
  int                   grid_q16 [CELLS];
  logic [47:0]          win_start;
  logic [47:0]          win_end;
  logic [31:0]          bin_scale;
  int                   mean_q16;
  logic [31:0]          inv_std_q16;
  bit                   stats_ok;
  logic [10:0]          crop_x;

  cell_read_t           pending_reads[$];
  int                   hot_cells[$];
  int                   sender_idle;
  int                   recv_idle;
  int                   error_count;
  longint               cycle_count;

  event_voxel_grid_accumulator #(
    .TIME_BINS  (BINS),
    .GRID_HEIGHT(HEIGHT),
    .GRID_WIDTH (WIDTH)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_crop_x_offset (cfg_crop_x_offset),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_window_start   (in_window_start),
    .in_window_end     (in_window_end),
    .in_event_time     (in_event_time),
    .in_event_x        (in_event_x),
    .in_event_y        (in_event_y),
    .in_event_polarity (in_event_polarity),
    .in_cell_index     (in_cell_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cell_value    (out_cell_value),
    .out_was_normalized(out_was_normalized)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Grid predictor
  // ---------------------------------------------------------------------------

  function automatic int clamp32(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -longint'(64'sd2147483648)) return 32'sh8000_0000;
    return int'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bit_w;
    root  = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= root + bit_w) begin
        v    = v - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  function automatic void clear_frame(logic [47:0] ws, logic [47:0] we);
    longint unsigned span;
    foreach (grid_q16[i]) grid_q16[i] = 0;
    hot_cells.delete();
    win_start   = ws;
    win_end     = we;
    span        = (we > ws) ? longint'(we - ws) : 64'd1;
    bin_scale   = 32'((64'(BINS - 1) << 28) / span);
    stats_ok    = 1'b0;
    mean_q16    = 0;
    inv_std_q16 = ONE_Q16;
  endfunction

  function automatic void add_weight(int idx, int unsigned w, bit positive);
    longint v;
    v = grid_q16[idx];
    v = positive ? v + longint'(w) : v - longint'(w);
    grid_q16[idx] = clamp32(v);
    hot_cells.insert(hot_cells.size(), idx);
  endfunction

  function automatic void bin_event(logic [47:0] t, logic [10:0] ex, logic [9:0] ey,
                                    bit positive);
    longint unsigned tn;
    longint unsigned bin;
    int unsigned     right_w;
    int              spot;
    if (t < win_start || t >= win_end) return;
    if (ex < crop_x) return;
    if (int'(ex - crop_x) >= WIDTH || int'(ey) >= HEIGHT) return;
    tn      = 64'(t - win_start) * 64'(bin_scale);
    bin     = tn >> 28;
    right_w = int'((tn >> 12) & 64'hFFFF);
    spot    = int'(ey) * WIDTH + int'(ex - crop_x);
    if (bin < BINS) add_weight(int'(bin) * PLANE + spot, 65536 - right_w, positive);
    if (bin + 1 < BINS) add_weight(int'(bin + 1) * PLANE + spot, right_w, positive);
  endfunction

  function automatic void compute_stats();
    longint          total;
    longint unsigned total_sq;
    longint unsigned nz;
    longint unsigned sq;
    longint          v;
    longint          avg;
    longint          avg_sq;
    longint          spread;
    longint unsigned sd;
    longint unsigned inv;
    total    = 0;
    total_sq = 0;
    nz       = 0;
    foreach (grid_q16[i]) begin
      v = grid_q16[i];
      if (v != 0) begin
        sq       = longint'(v * v) >> 16;
        total    = total + v;
        total_sq = (total_sq > ~64'd0 - sq) ? ~64'd0 : total_sq + sq;
        nz++;
      end
    end
    if (nz == 0) begin
      stats_ok    = 1'b0;
      mean_q16    = 0;
      inv_std_q16 = ONE_Q16;
      return;
    end
    avg      = total / longint'(nz);
    avg_sq   = longint'(64'(avg * avg) >> 16);
    spread   = $signed(total_sq / nz) - avg_sq;
    mean_q16 = clamp32(avg);
    if (spread > 0) begin
      sd  = int_sqrt(64'(spread) << 16);
      inv = (sd != 0) ? (64'd1 << 32) / sd : 64'(ONE_Q16);
      inv_std_q16 = (inv > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(inv);
    end else begin
      inv_std_q16 = ONE_Q16;
    end
    stats_ok = 1'b1;
  endfunction

  function automatic cell_read_t read_cell(logic [14:0] ci);
    cell_read_t r;
    longint     diff;
    longint     gain;
    r.value = 0;
    r.norm  = 1'b0;
    if (int'(ci) < CELLS) begin
      r.value = grid_q16[ci];
      if (r.value != 0 && stats_ok) begin
        diff    = longint'(r.value) - longint'(mean_q16);
        gain    = (inv_std_q16 > 32'(INV_CLAMP)) ? longint'(INV_CLAMP) : longint'(inv_std_q16);
        r.value = clamp32((diff * gain) / 65536);
        r.norm  = 1'b1;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: hold the request until accepted, then update the predictor.
  // in_valid stays high on return; the next request's idle pause or drain_requests drops it.
  // ---------------------------------------------------------------------------

  task automatic send_request(op_t op, logic [47:0] ws, logic [47:0] we, logic [47:0] et,
                              logic [10:0] ex, logic [9:0] ey, bit pol, logic [14:0] ci);
    while ($urandom_range(0, 99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_op             <= op;
    in_window_start   <= ws;
    in_window_end     <= we;
    in_event_time     <= et;
    in_event_x        <= ex;
    in_event_y        <= ey;
    in_event_polarity <= pol;
    in_cell_index     <= ci;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    case (op)
      OP_BEGIN:  clear_frame(ws, we);
      OP_EVENT:  bin_event(et, ex, ey, pol);
      OP_FINISH: compute_stats();
      default:   pending_reads.insert(pending_reads.size(), read_cell(ci));
    endcase
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic begin_frame(logic [47:0] ws, logic [47:0] we);
    send_request(OP_BEGIN, ws, we, rand48(), 11'($urandom), 10'($urandom), 1'($urandom),
                 15'($urandom));
  endtask

  task automatic send_event(logic [47:0] t, logic [10:0] ex, logic [9:0] ey, bit pol);
    send_request(OP_EVENT, rand48(), rand48(), t, ex, ey, pol, 15'($urandom));
  endtask

  task automatic finish_frame();
    send_request(OP_FINISH, rand48(), rand48(), rand48(), 11'($urandom), 10'($urandom),
                 1'($urandom), 15'($urandom));
  endtask

  task automatic read_request(logic [14:0] ci);
    send_request(OP_READ, rand48(), rand48(), rand48(), 11'($urandom), 10'($urandom),
                 1'($urandom), ci);
  endtask

  // Drop valid and hold off until every pending read has come back.
  task automatic drain_requests();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  // Write crop only on an idle block; every phase ends on a read, so the
  // last result marks the end of all work.
  task automatic write_crop(logic [10:0] value);
    drain_requests();
    repeat (10) @(posedge clk);
    cfg_valid         <= 1'b1;
    cfg_crop_x_offset <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    crop_x = value;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    $display("[%0t] ERROR %s", $realtime, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    cell_read_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reads.size() == 0) begin
        report_mismatch("cell read result with no request pending");
      end else begin
        want = pending_reads.pop_front();
        if (out_cell_value !== want.value)
          report_mismatch($sformatf("cell_value got %0d want %0d", out_cell_value,
                                    want.value));
        if (out_was_normalized !== want.norm)
          report_mismatch($sformatf("was_normalized got %0b want %0b", out_was_normalized,
                                    want.norm));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Before any frame: zero grid, no statistics, out-of-range index reads zero.
  task automatic test_after_reset();
    read_request(15'd0);
    read_request(15'(CELLS - 1));
    read_request(15'(CELLS));
    finish_frame();
    read_request(15'h7FFF);
  endtask

  // Window edges, crop and bounds drops, stats life cycle.
  task automatic test_window_and_bounds();
    begin_frame(48'd100, 48'd100);
    send_event(48'd100, crop_x, 10'd0, 1'b1);
    read_request(15'd0);
    begin_frame(48'd1000, 48'd6000);
    send_event(48'd999, crop_x, 10'd0, 1'b1);
    send_event(48'd6000, crop_x, 10'd0, 1'b1);
    send_event(48'd1000, crop_x, 10'd0, 1'b1);
    send_event(48'd5999, crop_x + 11'd63, 10'd63, 1'b0);
    send_event(48'd3000, crop_x - 11'd1, 10'd2, 1'b1);
    send_event(48'd3000, crop_x + 11'd64, 10'd2, 1'b1);
    send_event(48'd3000, crop_x, 10'd64, 1'b1);
    send_event(48'd3000, 11'h7FF, 10'h3FF, 1'b1);
    send_event(48'd2200, crop_x + 11'd1, 10'd1, 1'b1);
    read_request(15'd0);
    finish_frame();
    read_request(15'd0);
    read_request(15'd1);
    read_request(15'(4 * PLANE + 63 * WIDTH + 63));
    send_event(48'd3500, crop_x + 11'd1, 10'd1, 1'b0);
    read_request(15'(2 * PLANE + WIDTH + 1));
    begin_frame(TIME_MAX - 48'd1, TIME_MAX);
    send_event(TIME_MAX - 48'd1, crop_x, 10'd0, 1'b1);
    read_request(15'd0);
  endtask

  // Crop at its top: only sensor column 2047 lands in the grid.
  task automatic test_crop_max();
    begin_frame(48'd0, TIME_MAX);
    send_event(48'h8000_0000_0000, 11'h7FF, 10'd5, 1'b1);
    send_event(48'h1234, 11'h7FE, 10'd5, 1'b1);
    read_request(15'(5 * WIDTH));
    finish_frame();
    read_request(15'(5 * WIDTH));
    read_request(15'h7FFF);
  endtask

  task automatic random_frames(int frames);
    logic [47:0] ws;
    logic [47:0] we;
    logic [47:0] span;
    logic [47:0] t;
    logic [10:0] ex;
    logic [9:0]  ey;
    int          n_events;
    int          pick;
    for (int f = 0; f < frames; f++) begin
      ws   = rand48();
      pick = $urandom_range(0, 9);
      span = (pick == 0) ? rand48() : 48'($urandom_range(1, 5000));
      we   = (pick == 1) ? ws - 48'($urandom_range(0, 3)) : ws + span;
      begin_frame(ws, we);
      n_events = $urandom_range(60, 140);
      for (int e = 0; e < n_events; e++) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) t = ws + 48'(rand48() % (span == 0 ? 48'd1 : span));
        else if (pick < 90) t = ws - 48'd1;
        else if (pick < 95) t = we - 48'd1;
        else t = rand48();
        if ($urandom_range(0, 9) != 0) begin
          // Keep most activity in a small patch so cells build up.
          ex = crop_x + 11'($urandom_range(0, $urandom_range(0, 1) ? 7 : 63));
          ey = 10'($urandom_range(0, $urandom_range(0, 1) ? 7 : 63));
        end else begin
          ex = 11'($urandom);
          ey = 10'($urandom);
        end
        send_event(t, ex, ey, 1'($urandom_range(0, 99) < 70));
        if ($urandom_range(0, 19) == 0 && hot_cells.size() != 0)
          read_request(15'(hot_cells[$urandom_range(0, hot_cells.size() - 1)]));
      end
      if ($urandom_range(0, 7) != 0) finish_frame();
      for (int r = 0; r < 20; r++) begin
        if (hot_cells.size() != 0 && $urandom_range(0, 99) < 80)
          read_request(15'(hot_cells[$urandom_range(0, hot_cells.size() - 1)]));
        else
          read_request(15'($urandom));
      end
      if ($urandom_range(0, 2) == 0) begin
        // Late events: they land after the stats and must not refresh them.
        repeat (5) send_event(ws + 48'($urandom_range(0, 40)), crop_x + 11'($urandom_range(0, 7)),
                              10'($urandom_range(0, 7)), 1'($urandom));
        repeat (3)
          if (hot_cells.size() != 0)
            read_request(15'(hot_cells[$urandom_range(0, hot_cells.size() - 1)]));
      end
      if ($urandom_range(0, 3) == 0) drain_requests();
    end
    read_request(15'($urandom));
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_valid         <= 1'b0;
    cfg_crop_x_offset <= '0;
    in_valid          <= 1'b0;
    in_op             <= OP_BEGIN;
    in_window_start   <= '0;
    in_window_end     <= '0;
    in_event_time     <= '0;
    in_event_x        <= '0;
    in_event_y        <= '0;
    in_event_polarity <= 1'b0;
    in_cell_index     <= '0;
    sender_idle       = 0;
    recv_idle         = 0;
    error_count       = 0;
    cycle_count       = 0;
    crop_x            = '0;
    clear_frame('0, '0);
    bin_scale         = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle = 16;
    recv_idle   = 73;
    test_after_reset();
    write_crop(11'd5);
    test_window_and_bounds();
    write_crop(11'h7FF);
    test_crop_max();
    write_crop(11'($urandom_range(0, 1900)));
    random_frames(5);

    sender_idle = 73;
    recv_idle   = 16;
    write_crop(11'd0);
    random_frames(5);

    sender_idle = 0;
    recv_idle   = 0;
    write_crop(11'($urandom_range(1, 1980)));
    random_frames(5);

    drain_requests();
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/evga_pkg.sv
sv/evga_div.sv
sv/evga_sqrt.sv
sv/event_voxel_grid_accumulator.sv
bench/tb_event_voxel_grid_accumulator.sv
